/* hdl/henyey_greenstein_phase_eval_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the phase evaluation unit
// Immediate-style wrappers around concurrent properties on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef HENYEY_GREENSTEIN_PHASE_EVAL_UNIT_ASSERT_SVH
`define HENYEY_GREENSTEIN_PHASE_EVAL_UNIT_ASSERT_SVH

// same-cycle implication
`define HG_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HG_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hg_pkg.sv */
// ----------------------------------------------------------------------------
// hg_pkg
// Shared constants, register codes and inter-stage payload types.
// ----------------------------------------------------------------------------
package hg_pkg;

	localparam int ONE_Q14 = 16384;
	localparam logic signed [15:0] G_MAX = 16'sd16384;
	localparam logic signed [15:0] G_MIN = -16'sd16384;
	localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
	// round(2^32 / (4*pi))
	localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [31:0] DENS_ONE = 32'd65536;
	// density for g = 0
	localparam logic [31:0] DENS_ISO = 32'd5215;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 32;

	typedef enum logic [1:0] {
		REG_ASYM    = 2'd0,
		REG_COLOR_X = 2'd1,
		REG_COLOR_Y = 2'd2,
		REG_COLOR_Z = 2'd3
	} reg_idx_t;

	// c in Q30, numerator in Q60, zero-c flag
	typedef struct packed {
		logic [32:0] c30;
		logic [57:0] num;
		logic        zero;
	} crad_t;

	// adds sqrt(c) in Q30
	typedef struct packed {
		logic [32:0] c30;
		logic [31:0] root;
		logic [57:0] num;
		logic        zero;
	} root_t;

endpackage

/* hdl/hg_front.sv */
// ----------------------------------------------------------------------------
// hg_front
// Dot product, clamp, c = 1 + g^2 - 2*g*cos and numerator, four stages.
// ----------------------------------------------------------------------------
module hg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [15:0] in_dir_x,
	input  logic signed [15:0] in_dir_y,
	input  logic signed [15:0] in_dir_z,
	input  logic signed [15:0] out_dir_x,
	input  logic signed [15:0] out_dir_y,
	input  logic signed [15:0] out_dir_z,
	input  logic signed [15:0] asymmetry,
	output logic               out_valid,
	output hg_pkg::crad_t      out_item
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [28:0]        g2_s1;
	logic signed [29:0] cos_s2;
	logic [28:0]        a_s2;
	logic [29:0]        b_s2;
	logic signed [45:0] gc_s3;
	logic [57:0]        num_s3;
	logic [29:0]        b_s3;
	hg_pkg::crad_t      it_s4;

	logic signed [31:0] g2_full;
	logic signed [33:0] dot;
	logic signed [29:0] cos_w;
	logic signed [45:0] gc_w;
	logic signed [46:0] c42;
	logic [32:0]        c30_w;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: component products and g^2
	assign g2_full = asymmetry * asymmetry;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= in_dir_x * out_dir_x;
			py_s1 <= in_dir_y * out_dir_y;
			pz_s1 <= in_dir_z * out_dir_z;
			g2_s1 <= g2_full[28:0];
		end
	end

	// stage 2: sum and clamp cos to [-1, 1]
	assign dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);

	always_comb begin
		priority if (dot > 34'sd268435456) begin
			cos_w = 30'sd268435456;
		end else if (dot < -34'sd268435456) begin
			cos_w = -30'sd268435456;
		end else begin
			cos_w = signed'(dot[29:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s2 <= cos_w;
			a_s2   <= hg_pkg::ONE_Q28 - g2_s1;
			b_s2   <= {1'b0, hg_pkg::ONE_Q28} + {1'b0, g2_s1};
		end
	end

	// stage 3: g*cos and numerator a*K
	assign gc_w = 46'(asymmetry) * 46'(cos_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			gc_s3  <= gc_w;
			num_s3 <= 58'(a_s2) * 58'(hg_pkg::INV_4PI_Q32);
			b_s3   <= b_s2;
		end
	end

	// stage 4: c in Q42, truncated to Q30
	assign c42   = signed'({3'b000, b_s3, 14'd0}) - (47'(gc_s3) <<< 1);
	assign c30_w = c42[46] ? 33'd0 : c42[44:12];

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4.c30  <= c30_w;
			it_s4.num  <= num_s3;
			it_s4.zero <= (c30_w == 33'd0);
		end
	end

	assign out_valid = v_s4;
	assign out_item  = it_s4;

endmodule

/* hdl/hg_sqrt.sv */
// ----------------------------------------------------------------------------
// hg_sqrt
// Pipelined digit-by-digit square root of c30 * 2^30, one root bit a stage.
// ----------------------------------------------------------------------------
module hg_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  hg_pkg::crad_t in_item,
	output logic          out_valid,
	output hg_pkg::root_t out_item
);

	localparam int N = hg_pkg::SQRT_STEPS;

	logic          v_s    [N+1];
	logic [33:0]   rem_s  [N+1];
	logic [31:0]   root_s [N+1];
	hg_pkg::crad_t it_s   [N+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign it_s[0]   = in_item;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [63:0] rad;
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;

		// next radicand pair, trial divisor 4*root + 1
		assign rad   = {1'b0, it_s[k].c30, 30'd0};
		assign cur   = {rem_s[k], rad[63-2*k -: 2]};
		assign trial = 36'({root_s[k], 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? 34'(cur - trial) : cur[33:0];
				root_s[k+1] <= {root_s[k][30:0], ge};
				it_s[k+1]   <= it_s[k];
			end
		end
	end

	assign out_valid     = v_s[N];
	assign out_item.c30  = it_s[N].c30;
	assign out_item.root = root_s[N];
	assign out_item.num  = it_s[N].num;
	assign out_item.zero = it_s[N].zero;

endmodule

/* hdl/hg_div.sv */
// ----------------------------------------------------------------------------
// hg_div
// c^1.5 = c * sqrt(c), then restoring division num*2^16 / c^1.5 with
// saturation; one quotient bit a stage.
// ----------------------------------------------------------------------------
module hg_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  hg_pkg::root_t in_item,
	output logic          out_valid,
	output logic [31:0]   density
);

	localparam int N = hg_pkg::DIV_STEPS;

	logic        v_d0, v_fin;
	logic [64:0] den_d0;
	logic [57:0] num_d0;
	logic        zero_d0;
	logic [63:0] prod;
	logic [31:0] dens_fin;

	logic        v_s    [N+1];
	logic [64:0] rem_s  [N+1];
	logic [31:0] q_s    [N+1];
	logic [64:0] den_s  [N+1];
	logic [31:0] nb_s   [N+1];
	logic        ovf_s  [N+1];
	logic        zero_s [N+1];

	// denominator; c30 has bit 32 only for c = 4, low bits then zero
	assign prod = in_item.c30[31:0] * in_item.root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d0    <= 1'b0;
			v_s[0]  <= 1'b0;
			v_fin   <= 1'b0;
		end else if (en) begin
			v_d0    <= in_valid;
			v_s[0]  <= v_d0;
			v_fin   <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_d0  <= in_item.c30[32] ? {1'b0, in_item.root, 32'd0} : {1'b0, prod};
			num_d0  <= in_item.num;
			zero_d0 <= in_item.zero;
		end
	end

	// integer part check: quotient >= 2^32 when num >> 16 >= den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= 65'(num_d0[57:16]);
			q_s[0]    <= '0;
			den_s[0]  <= den_d0;
			nb_s[0]   <= {num_d0[15:0], 16'd0};
			ovf_s[0]  <= (65'(num_d0[57:16]) >= den_d0);
			zero_s[0] <= zero_d0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [65:0] cur;
		logic        ge;

		assign cur = {rem_s[k], nb_s[k][N-1-k]};
		assign ge  = (cur >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? 65'(cur - {1'b0, den_s[k]}) : cur[64:0];
				q_s[k+1]    <= {q_s[k][30:0], ge};
				den_s[k+1]  <= den_s[k];
				nb_s[k+1]   <= nb_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	// special cases: zero c gives 1.0, overflow saturates
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zero_s[N]) begin
				dens_fin <= hg_pkg::DENS_ONE;
			end else if (ovf_s[N]) begin
				dens_fin <= hg_pkg::SAT32;
			end else begin
				dens_fin <= q_s[N];
			end
		end
	end

	assign out_valid = v_fin;
	assign density   = dens_fin;

endmodule

/* hdl/hg_weigh.sv */
// ----------------------------------------------------------------------------
// hg_weigh
// Density times the three colour channels, Q2.14 scale, saturating.
// Second stage is the output register.
// ----------------------------------------------------------------------------
module hg_weigh (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] density,
	input  logic [15:0] color_x,
	input  logic [15:0] color_y,
	input  logic [15:0] color_z,
	output logic        out_valid,
	output logic [31:0] dens_out,
	output logic [31:0] wx_out,
	output logic [31:0] wy_out,
	output logic [31:0] wz_out
);

	logic        v_w1, v_w2;
	logic [31:0] dens_w1;
	logic [47:0] px_w1, py_w1, pz_w1;
	logic [31:0] dens_w2, wx_w2, wy_w2, wz_w2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w1 <= 1'b0;
			v_w2 <= 1'b0;
		end else if (en) begin
			v_w1 <= in_valid;
			v_w2 <= v_w1;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			dens_w1 <= density;
			px_w1   <= density * color_x;
			py_w1   <= density * color_y;
			pz_w1   <= density * color_z;
		end
	end

	// shift by 14 and saturate to 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			dens_w2 <= dens_w1;
			wx_w2   <= (|px_w1[47:46]) ? hg_pkg::SAT32 : px_w1[45:14];
			wy_w2   <= (|py_w1[47:46]) ? hg_pkg::SAT32 : py_w1[45:14];
			wz_w2   <= (|pz_w1[47:46]) ? hg_pkg::SAT32 : pz_w1[45:14];
		end
	end

	assign out_valid = v_w2;
	assign dens_out  = dens_w2;
	assign wx_out    = wx_w2;
	assign wy_out    = wy_w2;
	assign wz_out    = wz_w2;

endmodule

/* hdl/henyey_greenstein_phase_eval_unit.sv */
// ----------------------------------------------------------------------------
// henyey_greenstein_phase_eval_unit
// Henyey-Greenstein phase density from two unit directions and configured
// asymmetry, plus the density weighted by three colour channels.
//
//   channel  dir  width  contents
//   s_*      in   96     direction pair, Q1.14 each
//   m_*      out  128    density and weighted colours, Q16.16 each
//   cfg_*    in   2+16   register writes, no read-back
//
// One beat per cycle sustained while the output is not stalled; 4 front stages,
// 32 square-root stages (one root bit each), 35 stages for c^1.5 and the
// 32-bit restoring divide (one quotient bit each), 2 weighting stages.
// Reset clears all valid bits and loads g = 0, colours = 1.0.
// All stages advance together when the output register is empty or taken;
// a stalled output holds the whole pipeline and s_tready drops.
// ----------------------------------------------------------------------------
module henyey_greenstein_phase_eval_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y, out_dir_z
	input  logic [95:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// density, weighted_x, weighted_y, weighted_z
	output logic [127:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic signed [15:0] asymmetry_q;
	logic [15:0]        color_x_q, color_y_q, color_z_q;
	logic signed [15:0] wg;

	logic          en;
	logic          fr_valid, sq_valid, dv_valid;
	hg_pkg::crad_t fr_item;
	hg_pkg::root_t sq_item;
	logic [31:0]   dv_density;
	logic [31:0]   density, weighted_x, weighted_y, weighted_z;

	// register writes; asymmetry clamped to [-1, 1]
	assign wg = signed'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asymmetry_q <= '0;
			color_x_q   <= 16'(hg_pkg::ONE_Q14);
			color_y_q   <= 16'(hg_pkg::ONE_Q14);
			color_z_q   <= 16'(hg_pkg::ONE_Q14);
		end else if (cfg_we) begin
			unique case (hg_pkg::reg_idx_t'(cfg_index))
				hg_pkg::REG_ASYM: begin
					priority if (wg > hg_pkg::G_MAX) begin
						asymmetry_q <= hg_pkg::G_MAX;
					end else if (wg < hg_pkg::G_MIN) begin
						asymmetry_q <= hg_pkg::G_MIN;
					end else begin
						asymmetry_q <= wg;
					end
				end
				hg_pkg::REG_COLOR_X: color_x_q <= cfg_data;
				hg_pkg::REG_COLOR_Y: color_y_q <= cfg_data;
				hg_pkg::REG_COLOR_Z: color_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	hg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_dir_x  (signed'(s_tdata[15:0])),
		.in_dir_y  (signed'(s_tdata[31:16])),
		.in_dir_z  (signed'(s_tdata[47:32])),
		.out_dir_x (signed'(s_tdata[63:48])),
		.out_dir_y (signed'(s_tdata[79:64])),
		.out_dir_z (signed'(s_tdata[95:80])),
		.asymmetry (asymmetry_q),
		.out_valid (fr_valid),
		.out_item  (fr_item)
	);

	hg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_item   (fr_item),
		.out_valid (sq_valid),
		.out_item  (sq_item)
	);

	hg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_item   (sq_item),
		.out_valid (dv_valid),
		.density   (dv_density)
	);

	hg_weigh u_weigh (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.density   (dv_density),
		.color_x   (color_x_q),
		.color_y   (color_y_q),
		.color_z   (color_z_q),
		.out_valid (m_tvalid),
		.dens_out  (density),
		.wx_out    (weighted_x),
		.wy_out    (weighted_y),
		.wz_out    (weighted_z)
	);

	assign m_tdata = {weighted_z, weighted_y, weighted_x, density};

	// checks
`include "henyey_greenstein_phase_eval_unit_assert.svh"

	`HG_CHECK_NEXT(a_g_clamped, cfg_we && (cfg_index == hg_pkg::REG_ASYM), (asymmetry_q <= hg_pkg::G_MAX) && (asymmetry_q >= hg_pkg::G_MIN), "asymmetry register out of range")
	`HG_CHECK(a_unity_x, m_tvalid && (color_x_q == 16'(hg_pkg::ONE_Q14)), weighted_x == density, "unit colour X changed density")
	`HG_CHECK(a_isotropic, m_tvalid && (asymmetry_q == 16'sd0), density == hg_pkg::DENS_ISO, "isotropic density wrong")

endmodule
